// ===== design/wgtg_pkg.sv =====
// ----------------------------------------------------------------------------
// wgtg_pkg: shared types and constants of the go-to-goal controller
// Command and status bundles, result codes and CORDIC angle table.
// ----------------------------------------------------------------------------
package wgtg_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int ANG_BITS   = 24;
    localparam int CORDIC_ITS = 24;
    localparam int SQRT_ITS   = 17;

    localparam logic signed [28:0] PI_A      = 29'sd52707179;
    localparam logic signed [28:0] HALF_PI_A = 29'sd26353589;
    localparam logic signed [28:0] TWO_PI_A  = 29'sd105414357;
    localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;

    localparam logic [2:0] CFG_POINTS     = 3'd0;
    localparam logic [2:0] CFG_ANGLE_TOL  = 3'd1;
    localparam logic [2:0] CFG_DIST_TOL   = 3'd2;
    localparam logic [2:0] CFG_TURN_GAIN  = 3'd3;
    localparam logic [2:0] CFG_DRIVE_GAIN = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_POSE = 1'b1;

    typedef enum logic [1:0] {
        STAT_TURN    = 2'd0,
        STAT_DRIVE   = 2'd1,
        STAT_REACHED = 2'd2,
        STAT_DONE    = 2'd3
    } stat_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_WRITE, OP_POSE, OP_PREP, OP_QUAD, OP_NORM, OP_VEC, OP_ERR,
        OP_TMUL, OP_TRND, OP_SQX, OP_SQY, OP_SQRT, OP_ADV, OP_CPREP, OP_ROT,
        OP_C16, OP_DM1, OP_DM2, OP_DRND, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic zero;
        logic norm_ok;
        logic err_big;
        logic far;
    } sts_t;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic [24:0] atan_tab(input logic [4:0] i);
        logic [24:0] v;
        case (i)
            5'd0:    v = 25'd13176795;
            5'd1:    v = 25'd7778716;
            5'd2:    v = 25'd4110060;
            5'd3:    v = 25'd2086331;
            5'd4:    v = 25'd1047214;
            5'd5:    v = 25'd524117;
            5'd6:    v = 25'd262123;
            5'd7:    v = 25'd131069;
            5'd8:    v = 25'd65536;
            5'd9:    v = 25'd32768;
            5'd10:   v = 25'd16384;
            5'd11:   v = 25'd8192;
            5'd12:   v = 25'd4096;
            5'd13:   v = 25'd2048;
            5'd14:   v = 25'd1024;
            5'd15:   v = 25'd512;
            5'd16:   v = 25'd256;
            5'd17:   v = 25'd128;
            5'd18:   v = 25'd64;
            5'd19:   v = 25'd32;
            5'd20:   v = 25'd16;
            5'd21:   v = 25'd8;
            5'd22:   v = 25'd4;
            5'd23:   v = 25'd2;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [18:0] sat19(input logic signed [51:0] v);
        logic signed [18:0] r;
        if (v > 52'sd262143)
            r = 19'sd262143;
        else if (v < -52'sd262144)
            r = -19'sd262144;
        else
            r = v[18:0];
        return r;
    endfunction

endpackage

// ===== design/wgtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wgtg_ctrl: sequencer of the go-to-goal controller
// One-hot state machine issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module wgtg_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_kind,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  wgtg_pkg::sts_t sts,
    output wgtg_pkg::cmd_t cmd
);
    import wgtg_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_PREP  = 20'h00002,
        S_QUAD  = 20'h00004,
        S_NORM  = 20'h00008,
        S_VEC   = 20'h00010,
        S_ERR   = 20'h00020,
        S_CMP   = 20'h00040,
        S_TMUL  = 20'h00080,
        S_TRND  = 20'h00100,
        S_SQX   = 20'h00200,
        S_SQY   = 20'h00400,
        S_SQRT  = 20'h00800,
        S_DCMP  = 20'h01000,
        S_CPREP = 20'h02000,
        S_ROT   = 20'h04000,
        S_C16   = 20'h08000,
        S_DM1   = 20'h10000,
        S_DM2   = 20'h20000,
        S_DRND  = 20'h40000,
        S_OUT   = 20'h80000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= 5'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = 5'd0;
        ov_next    = ov_reg && !out_ready;
        cmd.op     = OP_NONE;
        cmd.iter   = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_POSE)
                    begin
                        cmd.op     = OP_POSE;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        cmd.op = OP_WRITE;
                    end
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = sts.fin ? S_OUT : S_QUAD;
            end
            S_QUAD:
            begin
                cmd.op     = OP_QUAD;
                state_next = sts.zero ? S_ERR : S_NORM;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (sts.norm_ok)
                    state_next = S_VEC;
            end
            S_VEC:
            begin
                cmd.op    = OP_VEC;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_ITS - 1))
                begin
                    iter_next  = 5'd0;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_CMP;
            end
            S_CMP:   state_next = sts.err_big ? S_TMUL : S_SQX;
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TRND;
            end
            S_TRND:
            begin
                cmd.op     = OP_TRND;
                state_next = S_OUT;
            end
            S_SQX:
            begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op    = OP_SQRT;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(SQRT_ITS - 1))
                begin
                    iter_next  = 5'd0;
                    state_next = S_DCMP;
                end
            end
            S_DCMP:
            begin
                if (sts.far)
                    state_next = S_CPREP;
                else
                begin
                    cmd.op     = OP_ADV;
                    state_next = S_OUT;
                end
            end
            S_CPREP:
            begin
                cmd.op     = OP_CPREP;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.op    = OP_ROT;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_ITS - 1))
                begin
                    iter_next  = 5'd0;
                    state_next = S_C16;
                end
            end
            S_C16:
            begin
                cmd.op     = OP_C16;
                state_next = S_DM1;
            end
            S_DM1:
            begin
                cmd.op     = OP_DM1;
                state_next = S_DM2;
            end
            S_DM2:
            begin
                cmd.op     = OP_DM2;
                state_next = S_DRND;
            end
            S_DRND:
            begin
                cmd.op     = OP_DRND;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = OP_EMIT;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

endmodule

// ===== design/wgtg_dp.sv =====
// ----------------------------------------------------------------------------
// wgtg_dp: datapath of the go-to-goal controller
// Waypoint store, config registers, shared CORDIC, square root and multiplier.
// ----------------------------------------------------------------------------
module wgtg_dp
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  wgtg_pkg::cmd_t           cmd,
    output wgtg_pkg::sts_t           sts,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    input  logic [3:0]               point_slot,
    input  logic [15:0]              point_x,
    input  logic [15:0]              point_y,
    input  logic [15:0]              pose_x,
    input  logic [15:0]              pose_y,
    input  logic signed [14:0]       heading,
    output wgtg_pkg::stat_t          status,
    output logic signed [18:0]       turn_rate,
    output logic signed [18:0]       drive_speed,
    output logic [4:0]               target_slot
);
    import wgtg_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int RSH = ANG_BITS - FRAC_BITS;

    logic [31:0] mem [MAX_POINTS];
    logic [31:0] rd_reg;

    logic [4:0]  pts_reg;
    logic [11:0] atol_reg;
    logic [15:0] dtol_reg, tgain_reg, dgain_reg;
    logic [4:0]  tgt_reg;

    logic [15:0]        px_reg, py_reg;
    logic signed [14:0] hd_reg;
    logic signed [16:0] dx_reg, dy_reg, err_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [28:0] cz_reg;
    logic               neg_reg;
    logic signed [51:0] prod_reg;
    logic [33:0]        n_reg, r_reg;
    logic [32:0]        bit_reg;
    logic signed [17:0] c16_reg;

    stat_t              res_st_reg, out_st_reg;
    logic signed [18:0] res_turn_reg, res_drive_reg, out_turn_reg, out_drive_reg;
    logic [4:0]         res_slot_reg, out_slot_reg;

    // config and target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg   <= 5'd16;
            atol_reg  <= 12'd41;
            dtol_reg  <= 16'd410;
            tgain_reg <= 16'd2560;
            dgain_reg <= 16'd512;
            tgt_reg   <= 5'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINTS:     pts_reg   <= cfg_data[4:0];
                    CFG_ANGLE_TOL:  atol_reg  <= cfg_data[11:0];
                    CFG_DIST_TOL:   dtol_reg  <= cfg_data;
                    CFG_TURN_GAIN:  tgain_reg <= cfg_data;
                    CFG_DRIVE_GAIN: dgain_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.op == OP_ADV)
                tgt_reg <= tgt_reg + 5'd1;
        end
    end

    // waypoint store, x low and y high
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE && 32'(point_slot) < 32'(MAX_POINTS))
            mem[AW'(point_slot)] <= {point_y, point_x};
        rd_reg <= mem[AW'(tgt_reg)];
    end

    // combinational helpers
    logic signed [16:0] qx, qy;
    logic signed [28:0] qz;
    logic signed [32:0] ay, mx, xs, ys, xf;
    logic signed [28:0] tab, e0, e1;
    logic               dsel, eneg;
    logic signed [16:0] ang;
    logic [33:0]        sq_t;
    logic [16:0]        root_q;
    logic signed [33:0] op_a;
    logic signed [17:0] op_b;
    logic signed [51:0] mul, rnd8, rnd24;

    always_comb
    begin
        qx = dx_reg;
        qy = dy_reg;
        qz = 29'sd0;
        if (dx_reg < 0)
        begin
            if (dy_reg >= 0)
            begin
                qx = dy_reg;
                qy = -dx_reg;
                qz = HALF_PI_A;
            end
            else
            begin
                qx = -dy_reg;
                qy = dx_reg;
                qz = -HALF_PI_A;
            end
        end

        ay  = (cy_reg < 0) ? -cy_reg : cy_reg;
        mx  = (cx_reg > ay) ? cx_reg : ay;
        xs  = cx_reg >>> cmd.iter;
        ys  = cy_reg >>> cmd.iter;
        tab = $signed({4'd0, atan_tab(cmd.iter)});
        dsel = (cmd.op == OP_ROT) ? (cz_reg >= 0) : (cy_reg < 0);

        ang = 17'((cz_reg + 29'sd2048) >>> RSH);

        sq_t   = r_reg + {1'b0, bit_reg};
        root_q = r_reg[16:0];

        // angle reduction to (-pi, pi], then fold into [-pi/2, pi/2]
        e0 = $signed({err_reg, 12'd0});
        if (e0 > PI_A)
            e0 = e0 - TWO_PI_A;
        else if (e0 <= -PI_A)
            e0 = e0 + TWO_PI_A;
        e1   = e0;
        eneg = 1'b0;
        if (e0 > HALF_PI_A)
        begin
            e1   = e0 - PI_A;
            eneg = 1'b1;
        end
        else if (e0 < -HALF_PI_A)
        begin
            e1   = e0 + PI_A;
            eneg = 1'b1;
        end

        xf = neg_reg ? -cx_reg : cx_reg;

        case (cmd.op)
            OP_TMUL:
            begin
                op_a = $signed({18'd0, tgain_reg});
                op_b = {err_reg[16], err_reg};
            end
            OP_SQX:
            begin
                op_a = {{17{dx_reg[16]}}, dx_reg};
                op_b = {dx_reg[16], dx_reg};
            end
            OP_SQY:
            begin
                op_a = {{17{dy_reg[16]}}, dy_reg};
                op_b = {dy_reg[16], dy_reg};
            end
            OP_DM1:
            begin
                op_a = $signed({18'd0, dgain_reg});
                op_b = $signed({1'b0, root_q});
            end
            OP_DM2:
            begin
                op_a = prod_reg[33:0];
                op_b = c16_reg;
            end
            default:
            begin
                op_a = 34'sd0;
                op_b = 18'sd0;
            end
        endcase
        mul   = op_a * op_b;
        rnd8  = (prod_reg + 52'sd128) >>> 8;
        rnd24 = (prod_reg + 52'sd8388608) >>> 24;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_POSE:
            begin
                px_reg <= pose_x;
                py_reg <= pose_y;
                hd_reg <= heading;
            end
            OP_PREP:
            begin
                dx_reg        <= $signed({1'b0, rd_reg[15:0]}) - $signed({1'b0, px_reg});
                dy_reg        <= $signed({1'b0, rd_reg[31:16]}) - $signed({1'b0, py_reg});
                res_st_reg    <= STAT_DONE;
                res_turn_reg  <= 19'sd0;
                res_drive_reg <= 19'sd0;
                res_slot_reg  <= tgt_reg;
            end
            OP_QUAD:
            begin
                cx_reg <= 33'(qx);
                cy_reg <= 33'(qy);
                cz_reg <= qz;
            end
            OP_NORM:
            begin
                if (!sts.norm_ok)
                begin
                    if (mx < 33'sd16777216)
                    begin
                        cx_reg <= cx_reg <<< 4;
                        cy_reg <= cy_reg <<< 4;
                    end
                    else
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                end
            end
            OP_VEC, OP_ROT:
            begin
                if (dsel)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - tab;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + tab;
                end
            end
            OP_ERR:  err_reg <= ang - 17'(hd_reg);
            OP_TMUL, OP_DM1, OP_DM2: prod_reg <= mul;
            OP_TRND:
            begin
                res_st_reg   <= STAT_TURN;
                res_turn_reg <= sat19(rnd8);
            end
            OP_SQX:  n_reg <= mul[33:0];
            OP_SQY:
            begin
                n_reg   <= n_reg + mul[33:0];
                r_reg   <= 34'd0;
                bit_reg <= 33'h1_0000_0000;
            end
            OP_SQRT:
            begin
                if (n_reg >= sq_t)
                begin
                    n_reg <= n_reg - sq_t;
                    r_reg <= (r_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_ADV:  res_st_reg <= STAT_REACHED;
            OP_CPREP:
            begin
                cx_reg  <= CORDIC_K;
                cy_reg  <= 33'sd0;
                cz_reg  <= e1;
                neg_reg <= eneg;
            end
            OP_C16:  c16_reg <= 18'((xf + 33'sd8192) >>> 14);
            OP_DRND:
            begin
                res_st_reg    <= STAT_DRIVE;
                res_drive_reg <= sat19(rnd24);
            end
            OP_EMIT:
            begin
                out_st_reg    <= res_st_reg;
                out_turn_reg  <= res_turn_reg;
                out_drive_reg <= res_drive_reg;
                out_slot_reg  <= res_slot_reg;
            end
            default: ;
        endcase
    end

    assign sts.fin     = (tgt_reg >= pts_reg) || (32'(tgt_reg) >= 32'(MAX_POINTS));
    assign sts.zero    = (dx_reg == 17'sd0) && (dy_reg == 17'sd0);
    assign sts.norm_ok = (mx >= 33'sd268435456);
    assign sts.err_big = (err_reg > $signed({5'd0, atol_reg}))
                      || (err_reg < -$signed({5'd0, atol_reg}));
    assign sts.far     = (root_q > {1'b0, dtol_reg});

    assign status      = out_st_reg;
    assign turn_rate   = out_turn_reg;
    assign drive_speed = out_drive_reg;
    assign target_slot = out_slot_reg;

endmodule

// ===== design/waypoint_go_to_goal_controller_unit.sv =====
// Sequence: a load beat is stored when it is accepted; a pose beat gives its result
// when finished, when turning, or when driving, the longest case (normalise, 24 atan2
// CORDIC steps, 17 square-root steps, 24 cosine CORDIC steps, multiplies). Flow:
// one pose beat at a time, the next taken once the result is registered; a new beat
// is taken while it waits.
// Reset: rst_n async; config to defaults, target to 0, store contents undefined.
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller_unit: waypoint follower top level
// Stream in/out, config write port, controller and datapath.
// ----------------------------------------------------------------------------
module waypoint_go_to_goal_controller_unit
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0] point_x[19:4] point_y[35:20] pose_x[51:36] pose_y[67:52]
    // heading[82:68] zero[87:83]
    input  logic [87:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // turn_rate[18:0] drive_speed[37:19] target_slot[42:38] zero[47:43]
    output logic [47:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import wgtg_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    stat_t              status;
    logic signed [18:0] turn_rate, drive_speed;
    logic [4:0]         target_slot;

    wgtg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wgtg_dp #(.MAX_POINTS(MAX_POINTS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_slot  (s_axis_tdata[3:0]),
        .point_x     (s_axis_tdata[19:4]),
        .point_y     (s_axis_tdata[35:20]),
        .pose_x      (s_axis_tdata[51:36]),
        .pose_y      (s_axis_tdata[67:52]),
        .heading     ($signed(s_axis_tdata[82:68])),
        .status      (status),
        .turn_rate   (turn_rate),
        .drive_speed (drive_speed),
        .target_slot (target_slot)
    );

    assign m_axis_tdata = {5'd0, target_slot, drive_speed, turn_rate};
    assign m_axis_tuser = status;

    a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_POSE) |=> !s_axis_tready)
        else $error("pose beat did not start processing");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_LOAD) |=> s_axis_tready)
        else $error("load beat stalled input");

    a_turn_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_TURN) |-> (m_axis_tdata[18:0] == 19'd0))
        else $error("turn rate set outside turning");

    a_drive_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_DRIVE) |-> (m_axis_tdata[37:19] == 19'd0))
        else $error("drive speed set outside driving");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the waypoint go-to-goal controller
// Loads waypoints and streams pose beats through the block while an in-bench
// fixed-point predictor (CORDIC atan2 and cosine, integer root) works out each
// command. Results are checked field by field, in order, across several
// register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import wgtg_pkg::*;

    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     SETTLE      = 120;

    typedef struct packed {
        logic               kind;
        logic [3:0]         slot;
        logic [15:0]        px;
        logic [15:0]        py;
        logic [15:0]        qx;
        logic [15:0]        qy;
        logic signed [14:0] heading;
    } beat_t;

    typedef struct packed {
        stat_t              status;
        logic signed [18:0] turn;
        logic signed [18:0] drive;
        logic [4:0]         tgt;
    } cmd_res_t;

    typedef struct packed {
        logic [15:0][31:0] store;
        longint            target;
        longint            pts;
        longint            atol;
        longint            dtol;
        longint            tgain;
        longint            dgain;
    } ctl_t;

    localparam longint ARC_TAB [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    beat_t    beats_todo [$];
    cmd_res_t commands_due [$];
    beat_t    beat_on_bus;
    ctl_t     live_ctl;
    ctl_t     plan_ctl;
    longint   cyc = 0;
    int       fail_count = 0;

    waypoint_go_to_goal_controller_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // bearing in 2^-24 rad
    function automatic longint bearing_q24(input longint y_in, input longint x_in);
        longint x, y, z, t, m, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = HALF_PI_A;
            end
            else
            begin
                t = x; x = -y; y = t; z = -HALF_PI_A;
            end
        end
        m = (y < 0) ? -y : y;
        if (x > m)
            m = x;
        while (m < (64'sd1 <<< 28))
        begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ARC_TAB[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ARC_TAB[i];
            end
        end
        return z;
    endfunction

    // cosine with 30 fraction bits, angle in 2^-24 rad
    function automatic longint cos_q30(input longint e_in);
        longint x, y, e, xs, ys;
        bit     neg;
        x = CORDIC_K;
        y = 0;
        e = e_in;
        neg = 1'b0;
        while (e > PI_A) e = e - TWO_PI_A;
        while (e <= -PI_A) e = e + TWO_PI_A;
        if (e > HALF_PI_A)
        begin
            e = e - PI_A; neg = 1'b1;
        end
        else if (e < -HALF_PI_A)
        begin
            e = e + PI_A; neg = 1'b1;
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (e >= 0)
            begin
                x = x - ys; y = y + xs; e = e - ARC_TAB[i];
            end
            else
            begin
                x = x + ys; y = y - xs; e = e + ARC_TAB[i];
            end
        end
        return neg ? -x : x;
    endfunction

    function automatic longint root_floor(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint clip19(input longint v);
        if (v > 262143)
            return 262143;
        if (v < -262144)
            return -262144;
        return v;
    endfunction

    function automatic longint waypoint_bearing(input ctl_t c, input beat_t b);
        longint dx, dy;
        dx = longint'(c.store[c.target][15:0]) - longint'(b.qx);
        dy = longint'(c.store[c.target][31:16]) - longint'(b.qy);
        return (bearing_q24(dy, dx) + 2048) >>> 12;
    endfunction

    // one beat through the controller; returns 1 when a command comes out
    function automatic bit steer_step(inout ctl_t c, input beat_t b, output cmd_res_t r);
        longint lim, dx, dy, hd, ang, err, aerr, reach, c16;
        if (b.kind == KIND_LOAD)
        begin
            c.store[b.slot] = {b.py, b.px};
            return 1'b0;
        end
        lim = (c.pts > 16) ? 16 : c.pts;
        r.tgt = c.target[4:0];
        r.turn = '0;
        r.drive = '0;
        if (c.target >= lim)
            r.status = STAT_DONE;
        else
        begin
            dx = longint'(c.store[c.target][15:0]) - longint'(b.qx);
            dy = longint'(c.store[c.target][31:16]) - longint'(b.qy);
            hd = longint'(b.heading);
            ang = (bearing_q24(dy, dx) + 2048) >>> 12;
            err = ang - hd;
            aerr = (err < 0) ? -err : err;
            if (aerr > c.atol)
            begin
                r.status = STAT_TURN;
                r.turn = 19'(clip19((c.tgain * err + 128) >>> 8));
            end
            else
            begin
                reach = root_floor(longint'(dx * dx + dy * dy));
                if (reach > c.dtol)
                begin
                    c16 = (cos_q30(err * 4096) + 8192) >>> 14;
                    r.status = STAT_DRIVE;
                    r.drive = 19'(clip19((c.dgain * reach * c16 + (64'sd1 <<< 23)) >>> 24));
                end
                else
                begin
                    r.status = STAT_REACHED;
                    c.target = c.target + 1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic bit idle_roll();
        if (cyc >= 3000 && cyc < 9000)
            return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_res_t r;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (steer_step(live_ctl, beat_on_bus, r))
                    commands_due.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (beats_todo.size() != 0 && !idle_roll())
                begin
                    beat_on_bus = beats_todo.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= beat_on_bus.kind;
                    s_axis_tdata  <= {5'b0, beat_on_bus.heading, beat_on_bus.qy,
                                      beat_on_bus.qx, beat_on_bus.py, beat_on_bus.px,
                                      beat_on_bus.slot};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        cmd_res_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= !idle_roll();
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (commands_due.size() == 0)
                begin
                    $error("unexpected result beat tdata=%h tuser=%0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    e = commands_due.pop_front();
                    if (m_axis_tuser != e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[18:0] != e.turn)
                    begin
                        $error("turn_rate: expected %0d, got %0d", e.turn,
                               $signed(m_axis_tdata[18:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[37:19] != e.drive)
                    begin
                        $error("drive_speed: expected %0d, got %0d", e.drive,
                               $signed(m_axis_tdata[37:19]));
                        fail_count++;
                    end
                    if (m_axis_tdata[42:38] != e.tgt)
                    begin
                        $error("target_slot: expected %0d, got %0d", e.tgt,
                               m_axis_tdata[42:38]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_beat(input beat_t b);
        cmd_res_t r;
        void'(steer_step(plan_ctl, b, r));
        beats_todo.push_back(b);
    endtask

    function automatic beat_t load_beat(input int s, input int x, input int y);
        beat_t b;
        b = '0;
        b.kind = KIND_LOAD;
        b.slot = s[3:0];
        b.px = x[15:0];
        b.py = y[15:0];
        return b;
    endfunction

    function automatic beat_t pose_beat(input int x, input int y, input int h);
        beat_t b;
        b = '0;
        b.kind = KIND_POSE;
        b.qx = x[15:0];
        b.qy = y[15:0];
        b.heading = h[14:0];
        return b;
    endfunction

    function automatic int clamp_int(input longint v, input longint lo, input longint hi);
        return (v < lo) ? int'(lo) : ((v > hi) ? int'(hi) : int'(v));
    endfunction

    task automatic queue_random(input int n);
        beat_t  b;
        int     sel, span;
        longint wx, wy, ang;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(199);
            b = pose_beat($urandom_range(65535), $urandom_range(65535),
                          int'($urandom_range(25736)) - 12868);
            wx = plan_ctl.store[plan_ctl.target[3:0]][15:0];
            wy = plan_ctl.store[plan_ctl.target[3:0]][31:16];
            if (sel < 20)
                b = load_beat($urandom_range(15), $urandom_range(65535),
                              $urandom_range(65535));
            else if (sel < 23)
            begin
                // arrive on the waypoint
                b.qx = wx[15:0];
                b.qy = wy[15:0];
                b.heading = '0;
            end
            else if (sel < 150)
            begin
                // roughly on course, near or far
                span = ($urandom_range(1)) ? 300 : 65535;
                b.qx = 16'(clamp_int(wx + int'($urandom_range(2 * span)) - span, 0, 65535));
                b.qy = 16'(clamp_int(wy + int'($urandom_range(2 * span)) - span, 0, 65535));
                if (plan_ctl.target < 16)
                begin
                    ang = waypoint_bearing(plan_ctl, b);
                    ang = ang + int'($urandom_range(2 * plan_ctl.atol + 80))
                          - plan_ctl.atol - 40;
                    b.heading = 15'(clamp_int(ang, -12868, 12868));
                end
            end
            queue_beat(b);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_POINTS:     live_ctl.pts   = val & 32'h1F;
            CFG_ANGLE_TOL:  live_ctl.atol  = val & 32'hFFF;
            CFG_DIST_TOL:   live_ctl.dtol  = val & 32'hFFFF;
            CFG_TURN_GAIN:  live_ctl.tgain = val & 32'hFFFF;
            CFG_DRIVE_GAIN: live_ctl.dgain = val & 32'hFFFF;
            default: ;
        endcase
        plan_ctl = live_ctl;
    endtask

    task automatic drain();
        while (beats_todo.size() != 0 || s_axis_tvalid || commands_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_all(input int p, input int a, input int d, input int tg,
                           input int dg);
        write_reg(CFG_POINTS, p);
        write_reg(CFG_ANGLE_TOL, a);
        write_reg(CFG_DIST_TOL, d);
        write_reg(CFG_TURN_GAIN, tg);
        write_reg(CFG_DRIVE_GAIN, dg);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        live_ctl = '0;
        live_ctl.pts = 16;
        live_ctl.atol = 41;
        live_ctl.dtol = 410;
        live_ctl.tgain = 2560;
        live_ctl.dgain = 512;
        plan_ctl = live_ctl;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill the store, then corners
        queue_beat(load_beat(0, 0, 0));
        queue_beat(load_beat(15, 65535, 65535));
        for (int s = 1; s < 15; s++)
            queue_beat(load_beat(s, $urandom_range(65535), $urandom_range(65535)));
        queue_beat(pose_beat(65535, 65535, 12868));
        queue_beat(pose_beat(65535, 0, -12868));
        queue_beat(pose_beat(0, 65535, 0));
        queue_beat(pose_beat(0, 0, 5));
        queue_beat(pose_beat(100, 0, 0));
        queue_beat(pose_beat(0, 0, 0));
        queue_beat(load_beat(1, 65535, 65535));
        queue_beat(pose_beat(0, 0, 3217));
        queue_beat(pose_beat(0, 0, -9651));
        queue_random(200);
        drain();

        set_all(16, 0, 0, 65535, 65535);
        queue_beat(pose_beat(0, 0, 12868));
        queue_random(200);
        drain();

        set_all(31, 300, 3000, 1234, 300);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd7, 16'h0001);
        queue_random(200);
        drain();

        set_all(16, 4095, 65535, 0, 0);
        queue_random(150);
        drain();

        set_all(1, 41, 410, 2560, 512);
        queue_random(100);
        drain();

        write_reg(CFG_POINTS, 0);
        queue_random(100);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
